>>> sv/mrn_pkg.sv
package mrn_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 40;
  localparam int SUM_W  = VAL_W + ADDR_W;
  localparam int FRAC_W = 22;
  localparam int QB     = FRAC_W + 1;       // quotient bits of a normalized word
  localparam int OUT_W  = FRAC_W + 2;
  localparam int N_W    = VAL_W + FRAC_W;   // scaled numerator width
  localparam int SC_W   = $clog2(SUM_W + 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_ZERO_RANGE = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normalized;
    status_t                 status;
    logic                    final_res;
  } out_word_t;

endpackage

>>> sv/mean_range_normalizer.sv
// channel | direction | handshake          | word
// in_     | input     | in_valid/in_stall   | in_word_t  (mode, value, last)
// out_    | output    | out_valid/out_stall | out_word_t (normalized, status, final_res)
//
// A closing load works out the mean on the one-bit-per-cycle shift-subtract
// divider. A read runs through sample store read, difference, clamp, scale,
// then QB divider steps. Empty or zero-range reads answer in the cycle after
// the word is taken.
// rst_n is synchronous, active low; the sample store is not cleared.
// A pending result held by out_stall blocks the next input word.
module mean_range_normalizer import mrn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIFF  = 7'b0000010,
    S_ABS   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_MPREP = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] max_r, max_nxt;
  logic signed [VAL_W-1:0] min_r, min_nxt;
  logic signed [VAL_W-1:0] mean_r, mean_nxt;
  logic [VAL_W-1:0]        range_r, range_nxt;
  logic [CNT_W-1:0]        rp_r, rp_nxt;
  logic                    closed_r, closed_nxt;
  logic                    op_mean_r, op_mean_nxt;
  logic signed [VAL_W:0]   d_r, d_nxt;
  logic [VAL_W-1:0]        m_r, m_nxt;
  logic                    neg_r, neg_nxt;
  logic                    final_r, final_nxt;
  logic [VAL_W-1:0]        rem_r, rem_nxt;
  logic [VAL_W-1:0]        dvs_r, dvs_nxt;
  logic [SUM_W-1:0]        num_r, num_nxt;
  logic [SC_W-1:0]         step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  // sample store
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] mem_q_r;
  logic             mem_we;
  logic             mem_re;

  logic                    in_accept;
  logic signed [VAL_W-1:0] x_s;
  logic signed [SUM_W-1:0] x_ext;
  logic [CNT_W-1:0]        cnt_base;
  logic signed [SUM_W-1:0] sum_base;
  logic [CNT_W-1:0]        rp_inc;
  logic                    rp_last;
  logic [VAL_W:0]          div_t;
  logic [VAL_W:0]          div_sub;
  logic                    div_ge;
  logic [VAL_W:0]          mag;
  logic [N_W-1:0]          n_scaled;
  logic                    sum_neg;
  logic [CNT_W-1:0]        cnt_half;
  logic [SUM_W-1:0]        mnum;
  logic [SUM_W-1:0]        mean_full;
  logic [OUT_W-1:0]        q_ext;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign x_s      = in_data.value;
  assign x_ext    = {{(SUM_W-VAL_W){x_s[VAL_W-1]}}, x_s};
  assign cnt_base = closed_r ? '0 : count_r;
  assign sum_base = closed_r ? '0 : sum_r;
  assign rp_inc   = rp_r + CNT_W'(1);
  assign rp_last  = (rp_inc == count_r);

  // one restoring divider step; the quotient bit shifts into num_r
  assign div_t   = {rem_r, num_r[SUM_W-1]};
  assign div_sub = div_t - {1'b0, dvs_r};
  assign div_ge  = (div_t >= {1'b0, dvs_r});

  assign mag      = d_r[VAL_W] ? (~d_r + 1'b1) : d_r;
  assign n_scaled = {m_r, {FRAC_W{1'b0}}} + {{(N_W-VAL_W){1'b0}}, (range_r >> 1)};

  // |sum| + count/2, negation folded in as invert plus carry
  assign sum_neg   = sum_r[SUM_W-1];
  assign cnt_half  = count_r >> 1;
  assign mnum      = (sum_neg ? ~sum_r : sum_r) + {{(SUM_W-CNT_W){1'b0}}, cnt_half}
                     + {{(SUM_W-1){1'b0}}, sum_neg};
  assign mean_full = sum_neg ? (~num_r + 1'b1) : num_r;
  assign q_ext     = {1'b0, num_r[QB-1:0]};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    mean_nxt      = mean_r;
    range_nxt     = range_r;
    rp_nxt        = rp_r;
    closed_nxt    = closed_r;
    op_mean_nxt   = op_mean_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    final_nxt     = final_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    num_nxt       = num_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.mode == MODE_LOAD) begin
            if (closed_r) begin
              rp_nxt     = '0;
              closed_nxt = 1'b0;
            end
            count_nxt = cnt_base;
            sum_nxt   = sum_base;
            // a load into a full store is dropped
            if (cnt_base < CNT_W'(DEPTH)) begin
              mem_we    = 1'b1;
              count_nxt = cnt_base + CNT_W'(1);
              sum_nxt   = sum_base + x_ext;
              if (cnt_base == '0) begin
                max_nxt = x_s;
                min_nxt = x_s;
              end else begin
                if (x_s > max_r) max_nxt = x_s;
                if (x_s < min_r) min_nxt = x_s;
              end
            end
            if (in_data.last) begin
              closed_nxt = 1'b1;
              state_nxt  = S_MPREP;
            end
          end else if (closed_r && (rp_r < count_r) && (range_r != '0)) begin
            mem_re    = 1'b1;
            final_nxt = rp_last;
            rp_nxt    = rp_inc;
            state_nxt = S_DIFF;
          end else begin
            out_valid_nxt           = 1'b1;
            out_word_nxt.normalized = '0;
            out_word_nxt.status     = ST_EMPTY;
            out_word_nxt.final_res  = 1'b0;
            if (closed_r && (rp_r < count_r)) begin
              out_word_nxt.status    = ST_ZERO_RANGE;
              out_word_nxt.final_res = rp_last;
              rp_nxt                 = rp_inc;
            end
          end
        end
      end

      S_DIFF: begin
        d_nxt     = {mem_q_r[VAL_W-1], mem_q_r} - {mean_r[VAL_W-1], mean_r};
        state_nxt = S_ABS;
      end

      S_ABS: begin
        neg_nxt   = d_r[VAL_W];
        m_nxt     = (mag > {1'b0, range_r}) ? range_r : mag[VAL_W-1:0];
        state_nxt = S_SCALE;
      end

      S_SCALE: begin
        // numerator >> QB is below the range, so only QB steps remain
        rem_nxt     = {1'b0, n_scaled[N_W-1:QB]};
        num_nxt     = {n_scaled[QB-1:0], {(SUM_W-QB){1'b0}}};
        dvs_nxt     = range_r;
        step_nxt    = SC_W'(QB);
        op_mean_nxt = 1'b0;
        state_nxt   = S_DIV;
      end

      S_MPREP: begin
        range_nxt   = max_r - min_r;
        rem_nxt     = '0;
        num_nxt     = mnum;
        dvs_nxt     = (count_r == '0) ? VAL_W'(1) : {{(VAL_W-CNT_W){1'b0}}, count_r};
        step_nxt    = SC_W'(SUM_W);
        op_mean_nxt = 1'b1;
        state_nxt   = S_DIV;
      end

      S_DIV: begin
        rem_nxt  = div_ge ? div_sub[VAL_W-1:0] : div_t[VAL_W-1:0];
        num_nxt  = {num_r[SUM_W-2:0], div_ge};
        step_nxt = step_r - SC_W'(1);
        if (step_r == SC_W'(1)) state_nxt = S_FIN;
      end

      S_FIN: begin
        if (op_mean_r) begin
          mean_nxt  = mean_full[VAL_W-1:0];
          state_nxt = S_IDLE;
        end else if (!(out_valid_r && out_stall)) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.normalized = neg_r ? (~q_ext + 1'b1) : q_ext;
          out_word_nxt.status     = ST_VALID;
          out_word_nxt.final_res  = final_r;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_base[ADDR_W-1:0]] <= x_s;
    if (mem_re) mem_q_r <= mem[rp_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      max_r       <= '0;
      min_r       <= '0;
      mean_r      <= '0;
      range_r     <= '0;
      rp_r        <= '0;
      closed_r    <= 1'b0;
      op_mean_r   <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      mean_r      <= mean_nxt;
      range_r     <= range_nxt;
      rp_r        <= rp_nxt;
      closed_r    <= closed_nxt;
      op_mean_r   <= op_mean_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    neg_r      <= neg_nxt;
    final_r    <= final_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    num_r      <= num_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
